/* rtl/uts_pkg.sv */
// Shared types, constants and helper functions of the UTF-8 title sanitizer.
`default_nettype none
package uts_pkg;

    localparam int unsigned CP_W    = 21;
    localparam int unsigned LEN_W   = 11;
    localparam int unsigned MAXL_W  = 10;
    localparam logic [LEN_W-1:0]  LEN_SAT        = 11'd1024;
    localparam logic [MAXL_W-1:0] MAX_LEN_RESET  = 10'd100;
    localparam logic [7:0]        SPACE_BYTE     = 8'h20;

    // Status codes of the closing result
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;

    typedef enum logic {
        K_CODE_POINT = 1'b0,
        K_TITLE_END  = 1'b1
    } t_kind;

    // One queue entry between decoder and encoder
    typedef struct packed {
        t_kind             kind;
        logic              in_last;   // belongs to the final byte of the title
        logic [CP_W-1:0]   cp;
    } t_entry;

    typedef enum logic {
        FS_RUN   = 1'b0,
        FS_FLUSH = 1'b1
    } t_front_state;

    typedef enum logic [1:0] {
        CLS_DROP  = 2'd0,
        CLS_SPACE = 2'd1,
        CLS_EMIT  = 2'd2
    } t_cp_class;

    // Sort a code point into dropped, whitespace or printable
    function automatic t_cp_class classify(input logic [CP_W-1:0] cp);
        t_cp_class c;
        c = CLS_EMIT;
        if (cp == 21'h09 || cp == 21'h0A || cp == 21'h0D || cp == 21'h20)
            c = CLS_SPACE;
        else if (cp <= 21'h1F || cp == 21'h7F)
            c = CLS_DROP;
        else if ((cp >= 21'h200B && cp <= 21'h200F) || (cp >= 21'h2028 && cp <= 21'h202E) ||
                 (cp >= 21'h2060 && cp <= 21'h2069) || cp == 21'hFEFF ||
                 (cp >= 21'hFFF9 && cp <= 21'hFFFC) || (cp >= 21'hD800 && cp <= 21'hDFFF))
            c = CLS_DROP;
        return c;
    endfunction

    // Shortest encoded length, 1 to 4
    function automatic logic [2:0] enc_len(input logic [CP_W-1:0] cp);
        logic [2:0] n;
        if (cp < 21'h80)         n = 3'd1;
        else if (cp < 21'h800)   n = 3'd2;
        else if (cp < 21'h10000) n = 3'd3;
        else                     n = 3'd4;
        return n;
    endfunction

    // Byte j of the shortest encoding of length n
    function automatic logic [7:0] enc_byte(input logic [CP_W-1:0] cp,
                                            input logic [2:0] n,
                                            input logic [1:0] j);
        logic [7:0] b;
        b = 8'h00;
        unique case (n)
            3'd1: b = {1'b0, cp[6:0]};
            3'd2: b = (j == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            3'd3: begin
                unique case (j)
                    2'd0:    b = {4'b1110, cp[15:12]};
                    2'd1:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            default: begin
                unique case (j)
                    2'd0: b = {5'b11110, cp[20:18]};
                    2'd1: b = {2'b10, cp[17:12]};
                    2'd2: b = {2'b10, cp[11:6]};
                    2'd3: b = {2'b10, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

/* rtl/uts_fifo.sv */
// Short entry queue between the decoder front and the encoder back.
`default_nettype none
module uts_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  uts_pkg::t_entry     i_data,
    output logic                o_full,
    input  wire                 i_pop,
    output uts_pkg::t_entry     o_data,
    output logic                o_empty
);
    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    uts_pkg::t_entry r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp, n_wp, n_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    // advance pointers with wrap
    always_comb begin
        n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= n_wp;
            if (i_pop)  r_rp <= n_rp;
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

    // hold entries
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end
endmodule
`default_nettype wire

/* rtl/uts_front.sv */
// Decoder front: accepts title bytes, assembles code points, flushes open sequences.
`default_nettype none
module uts_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire  [7:0]          i_byte,
    input  wire                 i_last,
    output logic                o_push,
    output uts_pkg::t_entry     o_entry,
    input  wire                 i_full
);
    uts_pkg::t_front_state r_state, n_state;
    logic [uts_pkg::CP_W-1:0] r_acc, n_acc;
    logic [1:0] r_exp, n_exp;
    logic [1:0] r_hc, n_hc;
    logic [7:0] r_held [3];
    logic [7:0] r_fb [2];
    logic [1:0] r_fb_n, r_fb_idx, n_fb_n, n_fb_idx;
    logic       r_in_last, n_in_last;

    // decoder step inputs and outputs
    logic        feed;
    logic [7:0]  fb;
    logic        cp_valid;
    logic [uts_pkg::CP_W-1:0] cp, acc2;
    logic        held_we;
    logic        load_rest;

    always_comb begin
        fb = (r_state == uts_pkg::FS_RUN) ? i_byte : r_fb[r_fb_idx[0]];
        acc2 = {r_acc[uts_pkg::CP_W-7:0], fb[5:0]};
    end

    // next state and decode
    always_comb begin
        n_state   = r_state;
        n_acc     = r_acc;
        n_exp     = r_exp;
        n_hc      = r_hc;
        n_fb_n    = r_fb_n;
        n_fb_idx  = r_fb_idx;
        n_in_last = r_in_last;
        o_ready   = 1'b0;
        feed      = 1'b0;
        load_rest = 1'b0;
        o_push    = 1'b0;
        o_entry   = '{kind: uts_pkg::K_CODE_POINT, in_last: r_in_last, cp: '0};
        cp_valid  = 1'b0;
        cp        = '0;
        held_we   = 1'b0;

        unique case (r_state)
            uts_pkg::FS_RUN: begin
                o_ready = !i_full;
                if (i_valid && !i_full) begin
                    feed      = 1'b1;
                    n_in_last = i_last;
                    if (i_last) begin
                        n_state  = uts_pkg::FS_FLUSH;
                        n_fb_n   = '0;
                        n_fb_idx = '0;
                    end
                end
            end
            uts_pkg::FS_FLUSH: begin
                if (r_fb_idx < r_fb_n) begin
                    if (!i_full) begin
                        feed     = 1'b1;
                        n_fb_idx = r_fb_idx + 1'b1;
                    end
                end else if (r_exp != 2'd0) begin
                    load_rest = 1'b1;
                    n_fb_n    = (r_hc >= 2'd2) ? r_hc - 1'b1 : 2'd0;
                    n_fb_idx  = '0;
                    n_exp     = '0;
                    n_hc      = '0;
                    n_acc     = '0;
                end else if (!i_full) begin
                    o_push  = 1'b1;
                    o_entry = '{kind: uts_pkg::K_TITLE_END, in_last: 1'b1, cp: '0};
                    n_state = uts_pkg::FS_RUN;
                end
            end
            default: n_state = uts_pkg::FS_RUN;
        endcase

        // one loose UTF-8 decode step
        if (feed) begin
            if (r_exp == 2'd0) begin
                if (fb < 8'h80) begin
                    cp_valid = 1'b1;
                    cp       = {13'd0, fb};
                end else if (fb[7:5] == 3'b110) begin
                    n_acc = {16'd0, fb[4:0]}; n_exp = 2'd1; n_hc = 2'd1; held_we = 1'b1;
                end else if (fb[7:4] == 4'b1110) begin
                    n_acc = {17'd0, fb[3:0]}; n_exp = 2'd2; n_hc = 2'd1; held_we = 1'b1;
                end else if (fb[7:3] == 5'b11110) begin
                    n_acc = {18'd0, fb[2:0]}; n_exp = 2'd3; n_hc = 2'd1; held_we = 1'b1;
                end
            end else begin
                n_exp = r_exp - 1'b1;
                n_acc = acc2;
                if (r_exp == 2'd1) begin
                    n_hc     = '0;
                    cp_valid = 1'b1;
                    cp       = acc2;
                    n_acc    = '0;
                end else if (r_hc != 2'd3) begin
                    held_we = 1'b1;
                    n_hc    = r_hc + 1'b1;
                end
            end
            if (cp_valid) begin
                o_push  = 1'b1;
                o_entry = '{kind: uts_pkg::K_CODE_POINT, in_last: n_in_last, cp: cp};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= uts_pkg::FS_RUN;
            r_acc     <= '0;
            r_exp     <= '0;
            r_hc      <= '0;
            r_fb_n    <= '0;
            r_fb_idx  <= '0;
            r_in_last <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_acc     <= n_acc;
            r_exp     <= n_exp;
            r_hc      <= n_hc;
            r_fb_n    <= n_fb_n;
            r_fb_idx  <= n_fb_idx;
            r_in_last <= n_in_last;
        end
    end

    // hold the bytes of the open sequence and the flush buffer
    always_ff @(posedge i_clk) begin
        if (held_we) begin
            if (r_exp == 2'd0) r_held[0] <= fb;
            else if (r_hc == 2'd1) r_held[1] <= fb;
            else r_held[2] <= fb;
        end
        if (load_rest) begin
            r_fb[0] <= r_held[1];
            r_fb[1] <= r_held[2];
        end
    end
endmodule
`default_nettype wire

/* rtl/uts_back.sv */
// Encoder back: filters code points, collapses whitespace, emits bytes and status.
`default_nettype none
module uts_back (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  uts_pkg::t_entry          i_entry,
    input  wire                      i_empty,
    output logic                     o_pop,
    input  wire  [uts_pkg::MAXL_W-1:0] i_max_len,
    output logic                     o_valid,
    input  wire                      i_ready,
    output logic [7:0]               o_byte,
    output logic                     o_has_byte,
    output logic                     o_run_end,
    output logic                     o_title_end,
    output logic [1:0]               o_status,
    output logic [uts_pkg::LEN_W-1:0] o_length
);
    logic r_pend, n_pend, r_start, n_start;
    logic [uts_pkg::LEN_W-1:0] r_cnt, n_cnt, cnt_inc;
    logic [2:0] r_pos, n_pos;
    logic       r_ov;
    logic [7:0] r_byte;
    logic       r_has, r_rend, r_tend;
    logic [1:0] r_st;
    logic [uts_pkg::LEN_W-1:0] r_len;

    logic       can_load, load;
    logic [7:0] l_byte;
    logic       l_has, l_rend, l_tend;
    logic [1:0] l_st;
    logic [uts_pkg::LEN_W-1:0] l_len;
    uts_pkg::t_cp_class cls;
    logic [2:0] n_enc, total, epos;

    assign can_load = !r_ov || i_ready;

    always_comb begin
        cls     = uts_pkg::classify(i_entry.cp);
        n_enc   = uts_pkg::enc_len(i_entry.cp);
        total   = n_enc + 3'(r_pend);
        epos    = r_pos - 3'(r_pend);
        cnt_inc = (r_cnt < uts_pkg::LEN_SAT) ? r_cnt + 1'b1 : r_cnt;
        n_pend  = r_pend;
        n_start = r_start;
        n_cnt   = r_cnt;
        n_pos   = r_pos;
        o_pop   = 1'b0;
        load    = 1'b0;
        l_byte  = '0;
        l_has   = 1'b0;
        l_rend  = 1'b0;
        l_tend  = 1'b0;
        l_st    = uts_pkg::ST_OK;
        l_len   = '0;
        if (!i_empty) begin
            unique case (i_entry.kind)
                uts_pkg::K_TITLE_END: begin
                    if (can_load) begin
                        load   = 1'b1;
                        o_pop  = 1'b1;
                        l_rend = 1'b1;
                        l_tend = 1'b1;
                        l_len  = r_cnt;
                        if (r_cnt == '0) l_st = uts_pkg::ST_EMPTY;
                        else if (r_cnt > {1'b0, i_max_len}) l_st = uts_pkg::ST_TOO_LONG;
                        // clear title state
                        n_pend  = 1'b0;
                        n_start = 1'b1;
                        n_cnt   = '0;
                        n_pos   = '0;
                    end
                end
                default: begin
                    unique case (cls)
                        uts_pkg::CLS_DROP: o_pop = 1'b1;
                        uts_pkg::CLS_SPACE: begin
                            o_pop = 1'b1;
                            if (!r_start) n_pend = 1'b1;
                        end
                        default: begin
                            if (can_load) begin
                                load   = 1'b1;
                                l_has  = 1'b1;
                                n_cnt  = cnt_inc;
                                l_len  = cnt_inc;
                                l_byte = (r_pend && r_pos == 3'd0) ? uts_pkg::SPACE_BYTE
                                       : uts_pkg::enc_byte(i_entry.cp, n_enc, epos[1:0]);
                                if (r_pos == total - 1'b1) begin
                                    o_pop   = 1'b1;
                                    l_rend  = !i_entry.in_last;
                                    n_pos   = '0;
                                    n_pend  = 1'b0;
                                    n_start = 1'b0;
                                end else begin
                                    n_pos = r_pos + 1'b1;
                                end
                            end
                        end
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            r_start <= 1'b1;
            r_cnt   <= '0;
            r_pos   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_pend  <= n_pend;
            r_start <= n_start;
            r_cnt   <= n_cnt;
            r_pos   <= n_pos;
            if (load) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= l_byte;
            r_has  <= l_has;
            r_rend <= l_rend;
            r_tend <= l_tend;
            r_st   <= l_st;
            r_len  <= l_len;
        end
    end

    assign o_valid     = r_ov;
    assign o_byte      = r_byte;
    assign o_has_byte  = r_has;
    assign o_run_end   = r_rend;
    assign o_title_end = r_tend;
    assign o_status    = r_st;
    assign o_length    = r_len;
endmodule
`default_nettype wire

/* rtl/utf8_title_sanitizer_top.sv */
// A completed code point goes through the queue into the encoder output register. The decoder
// takes one byte per cycle unless the queue is full or a flush runs; the encoder sends one output
// byte per cycle while the sink accepts, 1 to 5 per code point, and pops dropped or whitespace points.
// At title end the held bytes after a truncated lead byte are re-decoded, then the status result.
// Reset (synchronous, active low) clears all title state and sets max_length to 100.
`default_nettype none
module utf8_title_sanitizer_top #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [7:0]  i_s_tdata,    // [7:0] in_byte
    input  wire         i_s_tlast,
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [23:0] o_m_tdata,    // [7:0] out_byte, [9:8] status, [20:10] length, zero
    output logic        o_m_tlast,
    output logic [1:0]  o_m_tuser,    // [0] has_byte, [1] title_end
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [9:0]  i_cfg_data
);
    logic [uts_pkg::MAXL_W-1:0] r_max_len;
    logic push, pop, full, empty;
    uts_pkg::t_entry wr_entry, rd_entry;
    logic [7:0] ob;
    logic [1:0] ost;
    logic [uts_pkg::LEN_W-1:0] olen;

    // configuration register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_max_len <= uts_pkg::MAX_LEN_RESET;
        else if (i_cfg_valid) r_max_len <= i_cfg_data;
    end

    uts_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_s_tvalid), .o_ready(o_s_tready),
        .i_byte(i_s_tdata), .i_last(i_s_tlast),
        .o_push(push), .o_entry(wr_entry), .i_full(full)
    );

    uts_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_data(wr_entry), .o_full(full),
        .i_pop(pop), .o_data(rd_entry), .o_empty(empty)
    );

    uts_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_entry(rd_entry), .i_empty(empty), .o_pop(pop),
        .i_max_len(r_max_len),
        .o_valid(o_m_tvalid), .i_ready(i_m_tready),
        .o_byte(ob), .o_has_byte(o_m_tuser[0]), .o_run_end(o_m_tlast),
        .o_title_end(o_m_tuser[1]), .o_status(ost), .o_length(olen)
    );

    assign o_m_tdata = {3'd0, olen, ost, ob};
endmodule
`default_nettype wire

/* rtl/uts_checker.sv */
// Port-level checker for the sanitizer top level, with its bind.
`default_nettype none
module uts_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_m_tvalid,
    input wire        i_m_tready,
    input wire [23:0] o_m_tdata,
    input wire        o_m_tlast,
    input wire [1:0]  o_m_tuser
);
    // status result always closes the run
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1] |-> o_m_tlast && !o_m_tuser[0])
        else $error("title end without run end");

    // empty status carries zero length
    a_empty_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1] && o_m_tdata[9:8] == 2'd1 |-> o_m_tdata[20:10] == 11'd0)
        else $error("empty title with nonzero length");

    // byte results carry status ok and a nonzero count
    a_byte_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata[9:8] == 2'd0 && o_m_tdata[20:10] != 11'd0)
        else $error("byte result with bad status or length");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");
endmodule

bind utf8_title_sanitizer_top uts_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
    .o_m_tdata(o_m_tdata), .o_m_tlast(o_m_tlast), .o_m_tuser(o_m_tuser)
);
`default_nettype wire
